// ----- rtl/assert_macros.svh -----
// Assertion helpers for the rtl folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define ASSERT_DELAY(label, clk, rst_n, a, n, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> ##n (b)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, a, b)
`define ASSERT_DELAY(label, clk, rst_n, a, n, b)
`endif
`endif

// ----- rtl/btpc_pkg.sv -----
// ----------------------------------------------------------------------------
// btpc_pkg
// Types, constants and helpers for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int DIV_STEPS = 32;
    localparam int LAT       = 12 + 2 * DIV_STEPS;
    localparam int T5_IDX    = 7 + DIV_STEPS;

    localparam logic [31:0] C_T_OFS   = 32'd4000;
    localparam logic [31:0] C_P_K     = 32'd50000;
    localparam logic [31:0] C_X1_MUL  = 32'd3038;
    localparam logic [31:0] C_X2_MUL  = 32'hFFFFE343;
    localparam logic [31:0] C_P_OFS   = 32'd3791;
    localparam logic [31:0] C_W_OFS   = 32'd32768;
    localparam logic [31:0] C_RND8    = 32'd8;
    localparam logic [31:0] C_RND2    = 32'd2;

    typedef enum logic [2:0] {
        REG_AC1_AC2 = 3'd0,
        REG_AC3_AC4 = 3'd1,
        REG_AC5_AC6 = 3'd2,
        REG_B1_B2   = 3'd3,
        REG_MC_MD   = 3'd4,
        REG_OSS     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] raw_temp;
        logic [18:0] raw_press;
    } item_t;

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic signed [31:0] pressure_pa;
        logic               div_fault;
    } result_t;

    function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
        return 32'($signed(v) >>> n);
    endfunction

    function automatic logic [31:0] sx16(input logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    // one restoring step: returns {remainder, shifted numerator with quotient bit}
    function automatic logic [63:0] div_step(input logic [31:0] rem, input logic [31:0] num,
                                             input logic [31:0] den);
        logic [32:0] t;
        logic        q;
        t = {rem, num[31]};
        q = (t >= {1'b0, den});
        if (q)
        begin
            t = t - {1'b0, den};
        end
        return {t[31:0], num[30:0], q};
    endfunction

endpackage

// ----- rtl/baro_temp_pressure_compensate.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensate
// Integer temperature and pressure compensation, fully pipelined.
// Two 32-stage dividers lie between accepted start and done.
// Throughput: one item per cycle; busy is never raised.
// Reset clears configuration to zero and drops all items in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module baro_temp_pressure_compensate
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  btpc_pkg::item_t    item,
    output logic               busy,
    output logic               done,
    output btpc_pkg::result_t  result,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_wdata
);

    localparam int N = btpc_pkg::DIV_STEPS;
    localparam int L = btpc_pkg::LAT;

    logic [31:0] ac12_reg, ac34_reg, ac56_reg, b12_reg, mcmd_reg;
    logic [1:0]  oss_reg;
    logic [L-1:0] vpipe_reg;
    logic         accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ac12_reg <= '0;
            ac34_reg <= '0;
            ac56_reg <= '0;
            b12_reg  <= '0;
            mcmd_reg <= '0;
            oss_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (btpc_pkg::cfg_idx_t'(cfg_idx))
                btpc_pkg::REG_AC1_AC2: ac12_reg <= cfg_wdata;
                btpc_pkg::REG_AC3_AC4: ac34_reg <= cfg_wdata;
                btpc_pkg::REG_AC5_AC6: ac56_reg <= cfg_wdata;
                btpc_pkg::REG_B1_B2:   b12_reg  <= cfg_wdata;
                btpc_pkg::REG_MC_MD:   mcmd_reg <= cfg_wdata;
                btpc_pkg::REG_OSS:     oss_reg  <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vpipe_reg <= '0;
        end
        else
        begin
            vpipe_reg <= {vpipe_reg[L-2:0], accept};
        end
    end

    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    assign ac1 = btpc_pkg::sx16(ac12_reg[31:16]);
    assign ac2 = btpc_pkg::sx16(ac12_reg[15:0]);
    assign ac3 = btpc_pkg::sx16(ac34_reg[31:16]);
    assign ac4 = {16'd0, ac34_reg[15:0]};
    assign ac5 = {16'd0, ac56_reg[31:16]};
    assign ac6 = {16'd0, ac56_reg[15:0]};
    assign b1  = btpc_pkg::sx16(b12_reg[31:16]);
    assign b2  = btpc_pkg::sx16(b12_reg[15:0]);
    assign mc  = btpc_pkg::sx16(mcmd_reg[31:16]);
    assign md  = btpc_pkg::sx16(mcmd_reg[15:0]);

    // input and first multiply
    logic [15:0] ut0_reg;
    logic [18:0] up0_reg, up1_reg;
    logic [31:0] m1_reg;

    // temperature divider
    logic [31:0] trem_reg [0:N];
    logic [31:0] tnum_reg [0:N];
    logic [31:0] tden_reg [0:N];
    logic [31:0] tx1_reg  [0:N];
    logic [18:0] tup_reg  [0:N];
    logic        tneg_reg [0:N];
    logic        tflt_reg [0:N];

    logic [31:0] x1t_next, den_next, tnum_next, tden_next, a_next;
    always_comb
    begin
        x1t_next  = btpc_pkg::asr32(m1_reg, 5'd15);
        den_next  = x1t_next + md;
        a_next    = mc << 11;
        tnum_next = a_next[31] ? 32'd0 - a_next : a_next;
        tden_next = den_next[31] ? 32'd0 - den_next : den_next;
    end

    // temperature finish and pressure coefficients
    logic [31:0] b5_next, s_next, q_t;
    logic [15:0] t_next;
    logic [15:0] t1_t_reg, t2_t_reg, t3_t_reg, t4_t_reg, t5_t_reg;
    logic [31:0] t1_b6_reg;
    logic [18:0] t1_up_reg, t2_up_reg, t3_up_reg, t4_up_reg;
    logic        t1_flt_reg, t2_flt_reg, t3_flt_reg, t4_flt_reg, t5_flt_reg;
    logic [31:0] sq_reg, ac2b6_reg, ac3b6_reg;
    logic [31:0] b2b62_reg, b1b62_reg, x2a_reg, x1c_reg;
    logic [31:0] b3_reg, w_reg, b4_reg, b7_reg;

    always_comb
    begin
        q_t     = tnum_reg[N];
        b5_next = tx1_reg[N] + (tneg_reg[N] ? 32'd0 - q_t : q_t);
        s_next  = btpc_pkg::asr32(b5_next + btpc_pkg::C_RND8, 5'd4);
        if ($signed(s_next) > 32'sd32767)
        begin
            t_next = 16'h7FFF;
        end
        else if ($signed(s_next) < -32'sd32768)
        begin
            t_next = 16'h8000;
        end
        else
        begin
            t_next = s_next[15:0];
        end
    end

    logic [31:0] b62_next, x3_next, v_next, b3_next, w_next;
    always_comb
    begin
        b62_next = btpc_pkg::asr32(sq_reg, 5'd12);
        x3_next  = btpc_pkg::asr32(b2b62_reg, 5'd11) + x2a_reg;
        v_next   = (((32'(ac1 * 32'd4)) + x3_next) << oss_reg) + btpc_pkg::C_RND2;
        b3_next  = v_next[31] ? 32'd0 - ((32'd0 - v_next) >> 2) : (v_next >> 2);
        w_next   = btpc_pkg::asr32(x1c_reg + btpc_pkg::asr32(b1b62_reg, 5'd16)
                   + btpc_pkg::C_RND2, 5'd2) + btpc_pkg::C_W_OFS;
    end

    // pressure divider
    logic [31:0] prem_reg [0:N];
    logic [31:0] pnum_reg [0:N];
    logic [31:0] pden_reg [0:N];
    logic [15:0] pt_reg   [0:N];
    logic        psel_reg [0:N];
    logic        pflt_reg [0:N];

    // final correction
    logic [31:0] p_next, a8_next;
    logic [31:0] f1_p_reg, f2_p_reg, sq2_reg, m2_reg, m3_reg, x2_reg;
    logic [15:0] f1_t_reg, f2_t_reg;
    logic        f1_flt_reg, f2_flt_reg;
    logic [31:0] pf_next;
    btpc_pkg::result_t result_reg;

    always_comb
    begin
        p_next  = psel_reg[N] ? (pnum_reg[N] << 1) : pnum_reg[N];
        a8_next = btpc_pkg::asr32(p_next, 5'd8);
        pf_next = f2_p_reg + btpc_pkg::asr32(btpc_pkg::asr32(m3_reg, 5'd16) + x2_reg
                  + btpc_pkg::C_P_OFS, 5'd4);
    end

    always_ff @(posedge clk)
    begin
        ut0_reg <= item.raw_temp;
        up0_reg <= item.raw_press;

        m1_reg  <= 32'(({16'd0, ut0_reg} - ac6) * ac5);
        up1_reg <= up0_reg;

        trem_reg[0] <= '0;
        tnum_reg[0] <= tnum_next;
        tden_reg[0] <= tden_next;
        tx1_reg[0]  <= x1t_next;
        tup_reg[0]  <= up1_reg;
        tneg_reg[0] <= a_next[31] ^ den_next[31];
        tflt_reg[0] <= (den_next == 32'd0);

        t1_t_reg   <= t_next;
        t1_b6_reg  <= b5_next - btpc_pkg::C_T_OFS;
        t1_up_reg  <= tup_reg[N];
        t1_flt_reg <= tflt_reg[N];

        sq_reg     <= 32'(t1_b6_reg * t1_b6_reg);
        ac2b6_reg  <= 32'(ac2 * t1_b6_reg);
        ac3b6_reg  <= 32'(ac3 * t1_b6_reg);
        t2_t_reg   <= t1_t_reg;
        t2_up_reg  <= t1_up_reg;
        t2_flt_reg <= t1_flt_reg;

        b2b62_reg  <= 32'(b2 * b62_next);
        b1b62_reg  <= 32'(b1 * b62_next);
        x2a_reg    <= btpc_pkg::asr32(ac2b6_reg, 5'd11);
        x1c_reg    <= btpc_pkg::asr32(ac3b6_reg, 5'd13);
        t3_t_reg   <= t2_t_reg;
        t3_up_reg  <= t2_up_reg;
        t3_flt_reg <= t2_flt_reg;

        b3_reg     <= b3_next;
        w_reg      <= w_next;
        t4_t_reg   <= t3_t_reg;
        t4_up_reg  <= t3_up_reg;
        t4_flt_reg <= t3_flt_reg;

        b4_reg     <= 32'(ac4 * w_reg) >> 15;
        b7_reg     <= 32'(({13'd0, t4_up_reg} - b3_reg) * (btpc_pkg::C_P_K >> oss_reg));
        t5_t_reg   <= t4_t_reg;
        t5_flt_reg <= t4_flt_reg;

        prem_reg[0] <= '0;
        pnum_reg[0] <= b7_reg[31] ? b7_reg : (b7_reg << 1);
        pden_reg[0] <= b4_reg;
        psel_reg[0] <= b7_reg[31];
        pflt_reg[0] <= t5_flt_reg || (b4_reg == 32'd0);
        pt_reg[0]   <= t5_t_reg;

        f1_p_reg   <= p_next;
        sq2_reg    <= 32'(a8_next * a8_next);
        m2_reg     <= 32'(btpc_pkg::C_X2_MUL * p_next);
        f1_t_reg   <= pt_reg[N];
        f1_flt_reg <= pflt_reg[N];

        m3_reg     <= 32'(sq2_reg * btpc_pkg::C_X1_MUL);
        x2_reg     <= btpc_pkg::asr32(m2_reg, 5'd16);
        f2_p_reg   <= f1_p_reg;
        f2_t_reg   <= f1_t_reg;
        f2_flt_reg <= f1_flt_reg;

        result_reg.div_fault   <= f2_flt_reg;
        result_reg.temp_tenths <= f2_flt_reg ? 16'sd0 : $signed(f2_t_reg);
        result_reg.pressure_pa <= f2_flt_reg ? 32'sd0 : $signed(pf_next);
    end

    for (genvar k = 0; k < N; k++)
    begin : g_div
        logic [63:0] tstep, pstep;
        assign tstep = btpc_pkg::div_step(trem_reg[k], tnum_reg[k], tden_reg[k]);
        assign pstep = btpc_pkg::div_step(prem_reg[k], pnum_reg[k], pden_reg[k]);

        always_ff @(posedge clk)
        begin
            trem_reg[k+1] <= tstep[63:32];
            tnum_reg[k+1] <= tstep[31:0];
            tden_reg[k+1] <= tden_reg[k];
            tx1_reg[k+1]  <= tx1_reg[k];
            tup_reg[k+1]  <= tup_reg[k];
            tneg_reg[k+1] <= tneg_reg[k];
            tflt_reg[k+1] <= tflt_reg[k];

            prem_reg[k+1] <= pstep[63:32];
            pnum_reg[k+1] <= pstep[31:0];
            pden_reg[k+1] <= pden_reg[k];
            pt_reg[k+1]   <= pt_reg[k];
            psel_reg[k+1] <= psel_reg[k];
            pflt_reg[k+1] <= pflt_reg[k];
        end
    end

    assign done   = vpipe_reg[L-1];
    assign result = result_reg;

    `ASSERT_IMPLY(a_fault_zero, clk, rst_n, done && result.div_fault, result.temp_tenths == 16'sd0 && result.pressure_pa == 32'sd0)
    `ASSERT_IMPLY(a_done_latency, clk, rst_n, done, $past(accept, btpc_pkg::LAT))
    `ASSERT_DELAY(a_b4_fault, clk, rst_n, vpipe_reg[btpc_pkg::T5_IDX] && b4_reg == 32'd0, 36, done && result.div_fault)

endmodule
